FILE: sv/omni_wheel_kinematics_assert.svh
// Assertion helpers for the omni wheel kinematics block.
`ifndef OMNI_WHEEL_KINEMATICS_ASSERT_SVH
`define OMNI_WHEEL_KINEMATICS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OWK_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("omni wheel kinematics: assertion failed");

// Next-cycle implication, disabled during reset.
`define OWK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("omni wheel kinematics: assertion failed");

`endif

FILE: sv/owk_pkg.sv
`default_nettype none

package owk_pkg;

    localparam int SINE_TABLE_BITS = 10;

    localparam logic [15:0] HEAD_MASK = ~16'((1 << (16 - SINE_TABLE_BITS)) - 1);
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam logic [14:0] SIN_A = 15'd25736;
    localparam logic [13:0] SIN_B = 14'd10512;
    localparam logic [10:0] SIN_C = 11'd1160;

    localparam logic signed [17:0] K_COS30 = 18'sd56756;

    localparam logic signed [19:0] WHEEL_MAX = 20'sd524287;
    localparam logic signed [19:0] WHEEL_MIN = -20'sd524288;

    localparam logic CMD_WORLD = 1'b0;
    localparam logic CMD_ROBOT = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 2'd3;

    localparam logic [15:0] RST_TRANSLATION_GAIN = 16'd12868;
    localparam logic [15:0] RST_SPIN_GAIN = 16'd12106;
    localparam logic [15:0] RST_BODY_RADIUS = 16'd5997;
    localparam logic [15:0] RST_INV_WHEEL_RADIUS = 16'd8533;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        robot;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic [14:0] z_sin;
        logic        neg_sin;
        logic [14:0] z_cos;
        logic        neg_cos;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [15:0] translation_gain;
        logic [15:0] spin_gain;
        logic [15:0] body_radius;
        logic [15:0] inverse_wheel_radius;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/omni_wheel_kinematics.sv
`default_nettype none

`include "omni_wheel_kinematics_assert.svh"

// Three-wheel omni inverse kinematics. Takes one command per clock while the
// queue is not full: the front end decodes the heading into quadrant and
// in-quadrant angle and pushes the transaction into a 4-deep queue; the back
// end is a 15-stage multiply pipeline (sine/cosine polynomial, frame rotation,
// 120-degree mixing, gains, body radius, inverse wheel radius, saturation)
// ending in the output register. Throughput is one transaction per cycle
// while the output does not stall, set by the single-issue pipeline. An output
// stall freezes the back end, and the queue keeps taking input until it holds
// four transactions. Registers are written through i_cfg_we/i_cfg_index/
// i_cfg_data; the user must write them only while no transaction is in flight,
// which the block does not enforce; they take effect on the next command.
module omni_wheel_kinematics import owk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic signed [15:0]   i_vel_x,
    input  logic signed [15:0]   i_vel_y,
    input  logic signed [15:0]   i_yaw_rate,
    input  logic        [15:0]   i_heading,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [19:0]   o_wheel_speed_a,
    output logic signed [19:0]   o_wheel_speed_b,
    output logic signed [19:0]   o_wheel_speed_c,
    output logic                 o_saturated
);

    t_cfg   r_cfg;
    t_qstat w_qstat;
    t_item  w_push_item;
    t_item  w_head_item;
    logic   w_push;
    logic   w_pop;
    logic   w_any_rail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.translation_gain     <= RST_TRANSLATION_GAIN;
            r_cfg.spin_gain            <= RST_SPIN_GAIN;
            r_cfg.body_radius          <= RST_BODY_RADIUS;
            r_cfg.inverse_wheel_radius <= RST_INV_WHEEL_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRANSLATION_GAIN: r_cfg.translation_gain <= i_cfg_data;
                REG_SPIN_GAIN: r_cfg.spin_gain <= i_cfg_data;
                REG_BODY_RADIUS: r_cfg.body_radius <= i_cfg_data;
                REG_INV_WHEEL_RADIUS: r_cfg.inverse_wheel_radius <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    owk_front u_front (
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_yaw_rate (i_yaw_rate),
        .i_heading  (i_heading),
        .i_qstat    (w_qstat),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    owk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head_item),
        .o_stat  (w_qstat)
    );

    owk_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (w_head_item),
        .i_qstat         (w_qstat),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_wheel_speed_a (o_wheel_speed_a),
        .o_wheel_speed_b (o_wheel_speed_b),
        .o_wheel_speed_c (o_wheel_speed_c),
        .o_saturated     (o_saturated)
    );

    assign w_any_rail = (o_wheel_speed_a == WHEEL_MAX) || (o_wheel_speed_a == WHEEL_MIN) ||
                        (o_wheel_speed_b == WHEEL_MAX) || (o_wheel_speed_b == WHEEL_MIN) ||
                        (o_wheel_speed_c == WHEEL_MAX) || (o_wheel_speed_c == WHEEL_MIN);

    `OWK_ASSERT_IMM(a_sat_on_rail, i_clk, i_rst_n, o_out_valid && o_saturated, w_any_rail)
    `OWK_ASSERT_IMM(a_full_after_push, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid && !o_in_stall))
    `OWK_ASSERT_IMM(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_qstat.empty)

endmodule

`default_nettype wire

FILE: sv/owk_front.sv
`default_nettype none

module owk_front import owk_pkg::*; (
    input  logic               i_in_valid,
    input  logic               i_command,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_yaw_rate,
    input  logic        [15:0] i_heading,
    input  t_qstat             i_qstat,
    output logic               o_in_stall,
    output logic               o_push,
    output t_item              o_item
);

    typedef struct packed {
        logic [14:0] z;
        logic        neg;
    } t_quad;

    function automatic t_quad decode(input logic [15:0] a);
        t_quad q;
        q.neg = a[15];
        q.z   = a[14] ? 15'(QUARTER_TURN[14:0] - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        return q;
    endfunction

    logic [15:0] w_hd_sin;
    logic [15:0] w_hd_cos;
    t_quad       w_qs;
    t_quad       w_qc;

    assign w_hd_sin = i_heading & HEAD_MASK;
    assign w_hd_cos = w_hd_sin + QUARTER_TURN;
    assign w_qs     = decode(w_hd_sin);
    assign w_qc     = decode(w_hd_cos);

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    always_comb begin
        o_item.robot    = (i_command == CMD_ROBOT);
        o_item.vel_x    = i_vel_x;
        o_item.vel_y    = i_vel_y;
        o_item.yaw_rate = i_yaw_rate;
        o_item.z_sin    = w_qs.z;
        o_item.neg_sin  = w_qs.neg;
        o_item.z_cos    = w_qc.z;
        o_item.neg_cos  = w_qc.neg;
    end

endmodule

`default_nettype wire

FILE: sv/owk_queue.sv
`default_nettype none

module owk_queue import owk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_data,
    input  logic   i_pop,
    output t_item  o_data,
    output t_qstat o_stat
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;

    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

FILE: sv/owk_back.sv
`default_nettype none

module owk_back import owk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_item              i_item,
    input  t_qstat             i_qstat,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [19:0] o_wheel_speed_a,
    output logic signed [19:0] o_wheel_speed_b,
    output logic signed [19:0] o_wheel_speed_c,
    output logic               o_saturated
);

    localparam int NSTG = 14;

    logic            w_adv;
    logic [NSTG-1:0] r_vld;
    logic            r_out_valid;

    logic signed [16:0] w_tg;
    logic signed [16:0] w_sg;
    logic signed [16:0] w_br;
    logic signed [16:0] w_iw;

    assign w_tg = $signed({1'b0, i_cfg.translation_gain});
    assign w_sg = $signed({1'b0, i_cfg.spin_gain});
    assign w_br = $signed({1'b0, i_cfg.body_radius});
    assign w_iw = $signed({1'b0, i_cfg.inverse_wheel_radius});

    assign w_adv = !(r_out_valid && i_out_stall);
    assign o_pop = w_adv && !i_qstat.empty;

    // stage 1: z squared, yaw product
    logic [29:0]        w_zz_s;
    logic [29:0]        w_zz_c;
    logic [14:0]        r1_z2s, r1_z2c, r1_zs, r1_zc;
    logic               r1_negs, r1_negc, r1_robot;
    logic signed [15:0] r1_vx, r1_vy;
    logic signed [32:0] r1_pw;

    assign w_zz_s = 30'(i_item.z_sin) * 30'(i_item.z_sin);
    assign w_zz_c = 30'(i_item.z_cos) * 30'(i_item.z_cos);

    // stage 2: inner polynomial term, yaw rescale
    logic [25:0]        w_cz_s, w_cz_c;
    logic signed [32:0] w_pw_rnd;
    logic [13:0]        r2_t1s, r2_t1c;
    logic [14:0]        r2_z2s, r2_z2c, r2_zs, r2_zc;
    logic               r2_negs, r2_negc, r2_robot;
    logic signed [15:0] r2_vx, r2_vy;
    logic signed [20:0] r2_i2;

    assign w_cz_s   = 26'(SIN_C) * 26'(r1_z2s);
    assign w_cz_c   = 26'(SIN_C) * 26'(r1_z2c);
    assign w_pw_rnd = r1_pw + 33'sd2048;

    // stage 3: middle polynomial term
    logic [28:0]        w_tz_s, w_tz_c;
    logic [14:0]        r3_t2s, r3_t2c, r3_zs, r3_zc;
    logic               r3_negs, r3_negc, r3_robot;
    logic signed [15:0] r3_vx, r3_vy;
    logic signed [20:0] r3_i2;

    assign w_tz_s = 29'(r2_t1s) * 29'(r2_z2s);
    assign w_tz_c = 29'(r2_t1c) * 29'(r2_z2c);

    // stage 4: sine and cosine with quadrant sign
    logic [29:0]        w_mg_s, w_mg_c;
    logic signed [16:0] w_sn, w_cs;
    logic signed [16:0] r4_sn, r4_cs;
    logic               r4_robot;
    logic signed [15:0] r4_vx, r4_vy;
    logic signed [20:0] r4_i2;

    assign w_mg_s = 30'(r3_t2s) * 30'(r3_zs);
    assign w_mg_c = 30'(r3_t2c) * 30'(r3_zc);
    assign w_sn   = r3_negs ? -$signed({1'b0, w_mg_s[29:14]}) : $signed({1'b0, w_mg_s[29:14]});
    assign w_cs   = r3_negc ? -$signed({1'b0, w_mg_c[29:14]}) : $signed({1'b0, w_mg_c[29:14]});

    // stage 5: rotation products, body radius product
    logic signed [32:0] r5_pcx, r5_psy, r5_pcy, r5_psx;
    logic               r5_robot;
    logic signed [15:0] r5_vx, r5_vy;
    logic signed [37:0] r5_pbr;

    // stage 6: rotated velocity
    logic signed [33:0] w_rot_x, w_rot_y;
    logic signed [20:0] r6_rx, r6_ry;
    logic signed [37:0] r6_pbr;

    assign w_rot_x = 34'(r5_pcx) + 34'(r5_psy) + 34'sd8192;
    assign w_rot_y = 34'(r5_pcy) - 34'(r5_psx) + 34'sd8192;

    // stage 7: cos30 products
    logic signed [38:0] r7_mrx, r7_mry;
    logic signed [20:0] r7_rx, r7_ry;
    logic signed [37:0] r7_pbr;

    // stage 8: omni mixing
    logic signed [38:0] r8_a0, r8_a1;
    logic signed [37:0] r8_pbr;

    // stage 9: translation gain, split products
    logic signed [36:0] r9_p0l, r9_p1l;
    logic signed [35:0] r9_p0h, r9_p1h;
    logic signed [37:0] r9_pbr;

    // stage 10: gain rescale
    logic signed [56:0] w_f0, w_f1;
    logic signed [26:0] r10_i0, r10_i1;
    logic signed [37:0] r10_pbr;

    assign w_f0 = (57'(r9_p0h) <<< 20) + 57'(r9_p0l) + 57'sh8000000;
    assign w_f1 = (57'(r9_p1h) <<< 20) + 57'(r9_p1l) + 57'sh8000000;

    // stage 11: cos30 on first term
    logic signed [44:0] r11_mi0;
    logic signed [26:0] r11_i1;
    logic signed [37:0] r11_pbr;

    // stage 12: wheel sums
    logic signed [45:0] r12_s0, r12_s1, r12_s2;

    // stage 13: inverse wheel radius, split products
    logic signed [40:0] r13_pl0, r13_pl1, r13_pl2;
    logic signed [39:0] r13_ph0, r13_ph1, r13_ph2;

    // stage 14: rescale to Q12
    logic signed [63:0] w_g0, w_g1, w_g2;
    logic signed [39:0] r14_v0, r14_v1, r14_v2;

    assign w_g0 = (64'(r13_ph0) <<< 23) + 64'(r13_pl0) + 64'sh800000;
    assign w_g1 = (64'(r13_ph1) <<< 23) + 64'(r13_pl1) + 64'sh800000;
    assign w_g2 = (64'(r13_ph2) <<< 23) + 64'(r13_pl2) + 64'sh800000;

    // output clip
    logic               w_hi0, w_lo0, w_hi1, w_lo1, w_hi2, w_lo2;

    assign w_hi0 = r14_v0 > 40'(WHEEL_MAX);
    assign w_lo0 = r14_v0 < 40'(WHEEL_MIN);
    assign w_hi1 = r14_v1 > 40'(WHEEL_MAX);
    assign w_lo1 = r14_v1 < 40'(WHEEL_MIN);
    assign w_hi2 = r14_v2 > 40'(WHEEL_MAX);
    assign w_lo2 = r14_v2 < 40'(WHEEL_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[NSTG-2:0], !i_qstat.empty};
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_z2s   <= w_zz_s[28:14];
            r1_z2c   <= w_zz_c[28:14];
            r1_zs    <= i_item.z_sin;
            r1_zc    <= i_item.z_cos;
            r1_negs  <= i_item.neg_sin;
            r1_negc  <= i_item.neg_cos;
            r1_robot <= i_item.robot;
            r1_vx    <= i_item.vel_x;
            r1_vy    <= i_item.vel_y;
            r1_pw    <= 33'(i_item.yaw_rate) * 33'(w_sg);

            r2_t1s   <= SIN_B - 14'(w_cz_s[25:14]);
            r2_t1c   <= SIN_B - 14'(w_cz_c[25:14]);
            r2_z2s   <= r1_z2s;
            r2_z2c   <= r1_z2c;
            r2_zs    <= r1_zs;
            r2_zc    <= r1_zc;
            r2_negs  <= r1_negs;
            r2_negc  <= r1_negc;
            r2_robot <= r1_robot;
            r2_vx    <= r1_vx;
            r2_vy    <= r1_vy;
            r2_i2    <= 21'(w_pw_rnd >>> 12);

            r3_t2s   <= SIN_A - w_tz_s[28:14];
            r3_t2c   <= SIN_A - w_tz_c[28:14];
            r3_zs    <= r2_zs;
            r3_zc    <= r2_zc;
            r3_negs  <= r2_negs;
            r3_negc  <= r2_negc;
            r3_robot <= r2_robot;
            r3_vx    <= r2_vx;
            r3_vy    <= r2_vy;
            r3_i2    <= r2_i2;

            r4_sn    <= w_sn;
            r4_cs    <= w_cs;
            r4_robot <= r3_robot;
            r4_vx    <= r3_vx;
            r4_vy    <= r3_vy;
            r4_i2    <= r3_i2;

            r5_pcx   <= 33'(r4_cs) * 33'(r4_vx);
            r5_psy   <= 33'(r4_sn) * 33'(r4_vy);
            r5_pcy   <= 33'(r4_cs) * 33'(r4_vy);
            r5_psx   <= 33'(r4_sn) * 33'(r4_vx);
            r5_robot <= r4_robot;
            r5_vx    <= r4_vx;
            r5_vy    <= r4_vy;
            r5_pbr   <= 38'(r4_i2) * 38'(w_br);

            r6_rx    <= r5_robot ? 21'(r5_vx) : 21'(w_rot_x >>> 14);
            r6_ry    <= r5_robot ? 21'(r5_vy) : 21'(w_rot_y >>> 14);
            r6_pbr   <= r5_pbr;

            r7_mrx   <= 39'(r6_rx) * 39'(K_COS30);
            r7_mry   <= 39'(r6_ry) * 39'(K_COS30);
            r7_rx    <= r6_rx;
            r7_ry    <= r6_ry;
            r7_pbr   <= r6_pbr;

            r8_a0    <= (39'(r7_ry) <<< 15) - r7_mrx;
            r8_a1    <= -r7_mry - (39'(r7_rx) <<< 15);
            r8_pbr   <= r7_pbr;

            r9_p0l   <= 37'($signed({1'b0, r8_a0[19:0]})) * 37'(w_tg);
            r9_p1l   <= 37'($signed({1'b0, r8_a1[19:0]})) * 37'(w_tg);
            r9_p0h   <= 36'($signed(r8_a0[38:20])) * 36'(w_tg);
            r9_p1h   <= 36'($signed(r8_a1[38:20])) * 36'(w_tg);
            r9_pbr   <= r8_pbr;

            r10_i0   <= 27'(w_f0 >>> 28);
            r10_i1   <= 27'(w_f1 >>> 28);
            r10_pbr  <= r9_pbr;

            r11_mi0  <= 45'(r10_i0) * 45'(K_COS30);
            r11_i1   <= r10_i1;
            r11_pbr  <= r10_pbr;

            r12_s0   <= 46'(r11_mi0) - (46'(r11_i1) <<< 15) + 46'(r11_pbr);
            r12_s1   <= (46'(r11_i1) <<< 16) + 46'(r11_pbr);
            r12_s2   <= -46'(r11_mi0) - (46'(r11_i1) <<< 15) + 46'(r11_pbr);

            r13_pl0  <= 41'($signed({1'b0, r12_s0[22:0]})) * 41'(w_iw);
            r13_pl1  <= 41'($signed({1'b0, r12_s1[22:0]})) * 41'(w_iw);
            r13_pl2  <= 41'($signed({1'b0, r12_s2[22:0]})) * 41'(w_iw);
            r13_ph0  <= 40'($signed(r12_s0[45:23])) * 40'(w_iw);
            r13_ph1  <= 40'($signed(r12_s1[45:23])) * 40'(w_iw);
            r13_ph2  <= 40'($signed(r12_s2[45:23])) * 40'(w_iw);

            r14_v0   <= 40'(w_g0 >>> 24);
            r14_v1   <= 40'(w_g1 >>> 24);
            r14_v2   <= 40'(w_g2 >>> 24);

            o_wheel_speed_a <= w_hi0 ? WHEEL_MAX : (w_lo0 ? WHEEL_MIN : 20'(r14_v0));
            o_wheel_speed_b <= w_hi1 ? WHEEL_MAX : (w_lo1 ? WHEEL_MIN : 20'(r14_v1));
            o_wheel_speed_c <= w_hi2 ? WHEEL_MAX : (w_lo2 ? WHEEL_MIN : 20'(r14_v2));
            o_saturated     <= w_hi0 || w_lo0 || w_hi1 || w_lo1 || w_hi2 || w_lo2;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import owk_pkg::*; ();

    localparam int     LIMIT_CYCLES = 300000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     SETTLE       = 24;
    localparam longint HALF_Q16     = 32768;
    localparam longint COS30_Q16    = K_COS30;

    typedef struct packed {
        logic signed [19:0] a;
        logic signed [19:0] b;
        logic signed [19:0] c;
        logic               sat;
    } t_wheel_result;

    class wheel_speed_checker;
        longint        tgain;
        longint        sgain;
        longint        bradius;
        longint        inv_wradius;
        t_wheel_result pending_speeds[$];
        int            errors;
        int            mismatches;
        int            checked;
        int            world_cnt;
        int            robot_cnt;
        int            sat_cnt;
        int            reg_writes;

        function new();
            tgain       = RST_TRANSLATION_GAIN;
            sgain       = RST_SPIN_GAIN;
            bradius     = RST_BODY_RADIUS;
            inv_wradius = RST_INV_WHEEL_RADIUS;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            reg_writes++;
            case (idx)
                REG_TRANSLATION_GAIN: tgain       = val;
                REG_SPIN_GAIN:        sgain       = val;
                REG_BODY_RADIUS:      bradius     = val;
                REG_INV_WHEEL_RADIUS: inv_wradius = val;
                default: ;
            endcase
        endfunction

        function longint round_shift(longint x, int n);
            return (x + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function longint quarter_sine(longint z);
            longint z2;
            longint t;
            z2 = (z * z) >>> 14;
            t  = (longint'(SIN_C) * z2) >>> 14;
            t  = longint'(SIN_B) - t;
            t  = (t * z2) >>> 14;
            t  = longint'(SIN_A) - t;
            return (t * z) >>> 14;
        endfunction

        function longint sine_q14(logic [15:0] ang);
            longint f;
            longint s;
            f = longint'(ang[13:0]);
            s = ang[14] ? quarter_sine(16384 - f) : quarter_sine(f);
            return ang[15] ? -s : s;
        endfunction

        function longint clip_wheel(longint v, inout logic sat);
            if (v > longint'(WHEEL_MAX)) begin
                sat = 1'b1;
                return WHEEL_MAX;
            end
            if (v < longint'(WHEEL_MIN)) begin
                sat = 1'b1;
                return WHEEL_MIN;
            end
            return v;
        endfunction

        function void note_command(logic cmd, logic signed [15:0] vx, logic signed [15:0] vy,
                                   logic signed [15:0] yaw, logic [15:0] hd);
            longint        vxl, vyl, w, rx, ry, sn, cs;
            longint        a0, a1, i0, i1, i2, s0, s1, s2;
            logic [15:0]   hm;
            logic          sat;
            t_wheel_result r;
            vxl = vx;
            vyl = vy;
            w   = yaw;
            rx  = vxl;
            ry  = vyl;
            sat = 1'b0;
            if (cmd == CMD_WORLD) begin
                world_cnt++;
                hm = hd & HEAD_MASK;
                sn = sine_q14(hm);
                cs = sine_q14(16'(hm + QUARTER_TURN));
                rx = round_shift(cs * vxl + sn * vyl, 14);
                ry = round_shift(cs * vyl - sn * vxl, 14);
            end else begin
                robot_cnt++;
            end
            a0 = ry * HALF_Q16 - rx * COS30_Q16;
            a1 = -ry * COS30_Q16 - rx * HALF_Q16;
            i0 = round_shift(a0 * tgain, 28);
            i1 = round_shift(a1 * tgain, 28);
            i2 = round_shift(w * sgain, 12);
            s0 = COS30_Q16 * i0 - HALF_Q16 * i1 + bradius * i2;
            s1 = i1 * 65536 + bradius * i2;
            s2 = -COS30_Q16 * i0 - HALF_Q16 * i1 + bradius * i2;
            r.a   = 20'(clip_wheel(round_shift(s0 * inv_wradius, 24), sat));
            r.b   = 20'(clip_wheel(round_shift(s1 * inv_wradius, 24), sat));
            r.c   = 20'(clip_wheel(round_shift(s2 * inv_wradius, 24), sat));
            r.sat = sat;
            pending_speeds.push_back(r);
        endfunction

        function void check_speeds(logic signed [19:0] a, logic signed [19:0] b,
                                   logic signed [19:0] c, logic sat);
            t_wheel_result e;
            checked++;
            if (sat === 1'b1) sat_cnt++;
            if (pending_speeds.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: a=%0d b=%0d c=%0d sat=%0b", a, b, c, sat);
                return;
            end
            e = pending_speeds.pop_front();
            if (a !== e.a || b !== e.b || c !== e.c || sat !== e.sat) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: exp a=%0d b=%0d c=%0d sat=%0b,",
                             mismatches, e.a, e.b, e.c, e.sat,
                             " got a=%0d b=%0d c=%0d sat=%0b", a, b, c, sat);
            end
        endfunction

        function int pending();
            return pending_speeds.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 command = 1'b0;
    logic signed [15:0]   vel_x = '0;
    logic signed [15:0]   vel_y = '0;
    logic signed [15:0]   yaw_rate = '0;
    logic [15:0]          heading = '0;
    logic                 out_stall = 1'b0;
    wire                  o_in_stall;
    wire                  o_out_valid;
    wire signed [19:0]    o_wheel_speed_a;
    wire signed [19:0]    o_wheel_speed_b;
    wire signed [19:0]    o_wheel_speed_c;
    wire                  o_saturated;

    wheel_speed_checker sb = new();

    int send_idle_pct = 37;
    int recv_idle_pct = 80;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    omni_wheel_kinematics dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (command),
        .i_vel_x         (vel_x),
        .i_vel_y         (vel_y),
        .i_yaw_rate      (yaw_rate),
        .i_heading       (heading),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_wheel_speed_a (o_wheel_speed_a),
        .o_wheel_speed_b (o_wheel_speed_b),
        .o_wheel_speed_c (o_wheel_speed_c),
        .o_saturated     (o_saturated)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // accepted transactions on both sides
    always @(posedge i_clk) begin
        if (rst_n && in_valid && !o_in_stall)
            sb.note_command(command, vel_x, vel_y, yaw_rate, heading);
        if (rst_n && o_out_valid && !out_stall)
            sb.check_speeds(o_wheel_speed_a, o_wheel_speed_b, o_wheel_speed_c, o_saturated);
    end

    // output side: random stall, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic send_item(logic cmd, logic [15:0] vx, logic [15:0] vy,
                             logic [15:0] w, logic [15:0] hd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        vel_x    <= vx;
        vel_y    <= vy;
        yaw_rate <= w;
        heading  <= hd;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] tg, logic [15:0] sg,
                                logic [15:0] br, logic [15:0] iw);
        logic [15:0] vals[4];
        vals = '{tg, sg, br, iw};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        if ($urandom_range(0, 3) == 0)
            return {2'($urandom_range(0, 3)), 14'($urandom_range(0, 3) * 16'h003F)};
        return 16'($urandom);
    endfunction

    task automatic send_random(int n);
        logic cmd;
        for (int i = 0; i < n; i++) begin
            cmd = $urandom_range(0, 2) == 0 ? CMD_ROBOT : CMD_WORLD;
            send_item(cmd, pick_velocity(), pick_velocity(), pick_velocity(), pick_heading());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers
        send_item(CMD_ROBOT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_ROBOT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234);
        send_item(CMD_ROBOT, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_item(CMD_ROBOT, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        send_item(CMD_ROBOT, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_item(CMD_ROBOT, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_item(CMD_ROBOT, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_WORLD, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_WORLD, 16'h1000, 16'h0000, 16'h0000, 16'h4000);
        send_item(CMD_WORLD, 16'h1000, 16'h0000, 16'h0000, 16'h8000);
        send_item(CMD_WORLD, 16'h1000, 16'h0000, 16'h0000, 16'hC000);
        send_item(CMD_WORLD, 16'h0000, 16'h1000, 16'h0000, 16'hFFFF);
        send_item(CMD_WORLD, 16'h1000, 16'h1000, 16'h0000, 16'h003F);
        send_item(CMD_WORLD, 16'h1000, 16'h1000, 16'h0000, 16'h0040);
        send_item(CMD_WORLD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000);
        send_item(CMD_WORLD, 16'h8000, 16'h8000, 16'h8000, 16'hA000);
        send_item(CMD_WORLD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555);
        wait_for_results();

        // zero gains and radii
        write_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_WORLD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1000);
        send_item(CMD_ROBOT, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
        wait_for_results();

        // gains and radii at full scale
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_WORLD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000);
        send_item(CMD_ROBOT, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000);
        send_item(CMD_ROBOT, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        wait_for_results();

        // sender 37%, receiver 80%
        write_config(RST_TRANSLATION_GAIN, RST_SPIN_GAIN, RST_BODY_RADIUS,
                     RST_INV_WHEEL_RADIUS);
        send_random(220);
        wait_for_results();
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(160);
        wait_for_results();

        // sender 80%, receiver 37%
        send_idle_pct = 80;
        recv_idle_pct = 37;
        write_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0100);
        send_random(100);
        wait_for_results();
        write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(220);
        wait_for_results();

        // no idling; long output hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_random(40);
        wait_for_results();
        write_config(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                     16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
        send_random(200);
        wait_for_results();
        write_config(RST_TRANSLATION_GAIN, RST_SPIN_GAIN, RST_BODY_RADIUS,
                     RST_INV_WHEEL_RADIUS);
        send_random(210);
        wait_for_results();

        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0d expected results never arrived", sb.pending());
        end
        $display("covered %0d commands (%0d world frame, %0d robot frame), %0d clipped results",
                 sb.world_cnt + sb.robot_cnt, sb.world_cnt, sb.robot_cnt, sb.sat_cnt);
        $display("%0d results checked over %0d register writes, %0d mismatches",
                 sb.checked, sb.reg_writes, sb.mismatches);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
